// ----- hw/rtl/bounding_sphere_grow_top_defines.svh -----
// Assertion macros shared by the bounding sphere RTL.
`ifndef BOUNDING_SPHERE_GROW_TOP_DEFINES_SVH
`define BOUNDING_SPHERE_GROW_TOP_DEFINES_SVH

// Condition in the same cycle implies a consequence in that cycle.
`define BSG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies a consequence in the following cycle.
`define BSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/bsg_pkg.sv -----
// Package with widths and the sequencer state type of the bounding sphere block.
package bsg_pkg;
   localparam int CoordW  = 32;
   localparam int RadiusW = 31;
   localparam int MagW    = 33;
   localparam int SumW    = 68;
   localparam int RootW   = 33;
   localparam int RootRemW = 35;
   localparam int CntW    = 6;
   localparam int RootSteps = 34;
   localparam int DivSteps  = 33;
   localparam int ReqDataW = 128;
   localparam int RspDataW = 136;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_SQX  = 10'b0000000010,
      ST_SQY  = 10'b0000000100,
      ST_SQZ  = 10'b0000001000,
      ST_TEST = 10'b0000010000,
      ST_ROOT = 10'b0000100000,
      ST_SETK = 10'b0001000000,
      ST_MUL  = 10'b0010000000,
      ST_DIV  = 10'b0100000000,
      ST_MOVE = 10'b1000000000
   } state_type;

   localparam logic KIND_MERGE = 1'b0;
   localparam logic KIND_LOAD  = 1'b1;
endpackage

// ----- hw/rtl/bounding_sphere_grow_top.sv -----
// Bounding sphere grow block: top level with its sequencer and shared multiplier.
// A load item (tuser 1) is stored at once and its result is offered the next cycle.
// A merge item runs three squaring passes and one enclosure test on a single shared
// 33x33 multiplier, then, when the sphere must grow, a 34-step square root (two bits
// a cycle) and for each axis one multiply and a 33-step restoring division (one bit a
// cycle). An enclosed or replacing merge steps through SQX, SQY, SQZ and TEST and offers
// its registered result after TEST; a growing merge goes on through ROOT and SETK and,
// for each axis, MUL, DIV and MOVE. One item is handled at a time and the input is not
// ready until the previous result has been taken.
`include "bounding_sphere_grow_top_defines.svh"
module bounding_sphere_grow_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // in_x [31:0], in_y [63:32], in_z [95:64], in_radius [126:96], zero [127]
   input  logic [bsg_pkg::ReqDataW-1:0]  req_tdata,
   // kind [0]
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_x [31:0], out_y [63:32], out_z [95:64], out_radius [126:96],
   // grew [127], saturated [128], zero [135:129]
   output logic [bsg_pkg::RspDataW-1:0]  rsp_tdata
);
   import bsg_pkg::*;

   state_type state_ff, state_in;
   logic [CoordW-1:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [RadiusW-1:0] rad_ff, rad_in;
   logic [CoordW-1:0]  ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic [RadiusW-1:0] ir_ff, ir_in;
   logic [SumW-1:0]    acc_ff, acc_in;
   logic [RootRemW-1:0] rrem_ff, rrem_in;
   logic [RootW-1:0]   root_ff, root_in;
   logic [RootW-1:0]   k_ff, k_in;
   logic [RootW-1:0]   nr_ff, nr_in;
   logic [MagW-1:0]    drem_ff, drem_in;
   logic [MagW-1:0]    dlo_ff, dlo_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [1:0]         axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               grew_ff, grew_in, sat_ff, sat_in;

   logic               accept;
   logic [MagW-1:0]    op_a, op_b;
   logic [2*MagW-1:0]  product;
   logic [CoordW-1:0]  sel_in, sel_c;
   logic [MagW-1:0]    delta, delta_mag;
   logic [RadiusW-1:0] t_mag;
   logic               r1_ge_r2, covered;
   logic [RootRemW+1:0] root_try, root_trial;
   logic [MagW:0]      div_try;
   logic [RootW:0]     rsum;
   logic [MagW:0]      moved;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, sat_ff, grew_ff, rad_ff, cz_ff, cy_ff, cx_ff};

   // Axis selection for the squaring passes and the centre move.
   always_comb begin
      case (axis_ff)
         2'd0:    begin sel_in = ix_ff; sel_c = cx_ff; end
         2'd1:    begin sel_in = iy_ff; sel_c = cy_ff; end
         default: begin sel_in = iz_ff; sel_c = cz_ff; end
      endcase
      delta     = {sel_in[CoordW-1], sel_in} - {sel_c[CoordW-1], sel_c};
      delta_mag = delta[MagW-1] ? (~delta + 1'b1) : delta;
   end

   // Radius difference for the enclosure test.
   assign r1_ge_r2 = rad_ff >= ir_ff;
   assign t_mag    = r1_ge_r2 ? (rad_ff - ir_ff) : (ir_ff - rad_ff);

   // Shared multiplier with its operand selection.
   always_comb begin
      if (state_ff == ST_TEST) begin
         op_a = {2'b00, t_mag};
         op_b = {2'b00, t_mag};
      end else if (state_ff == ST_MUL) begin
         op_a = delta_mag;
         op_b = k_ff;
      end else begin
         op_a = delta_mag;
         op_b = delta_mag;
      end
   end
   assign product = op_a * op_b;
   assign covered = acc_ff <= {2'b00, product};

   // Square root and division steps.
   assign root_try   = {rrem_ff, acc_ff[SumW-1 -: 2]};
   assign root_trial = {2'b00, root_ff, 2'b01};
   assign div_try    = {drem_ff, dlo_ff[MagW-1]};
   assign rsum  = {3'b000, rad_ff} + {3'b000, ir_ff} + {1'b0, root_ff};
   assign moved = delta[MagW-1] ? ({sel_c[CoordW-1], sel_c} - {1'b0, dlo_ff})
                                : ({sel_c[CoordW-1], sel_c} + {1'b0, dlo_ff});

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; rad_in = rad_ff;
      ix_in = ix_ff; iy_in = iy_ff; iz_in = iz_ff; ir_in = ir_ff;
      acc_in = acc_ff; rrem_in = rrem_ff; root_in = root_ff;
      k_in = k_ff; nr_in = nr_ff; drem_in = drem_ff; dlo_in = dlo_ff;
      cnt_in = cnt_ff; axis_in = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      grew_in = grew_ff; sat_in = sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ix_in = req_tdata[31:0];
               iy_in = req_tdata[63:32];
               iz_in = req_tdata[95:64];
               ir_in = req_tdata[126:96];
               axis_in = 2'd0;
               if (req_tuser == KIND_LOAD) begin
                  cx_in = req_tdata[31:0];
                  cy_in = req_tdata[63:32];
                  cz_in = req_tdata[95:64];
                  rad_in = req_tdata[126:96];
                  grew_in = 1'b1;
                  sat_in = 1'b0;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            acc_in = {2'b00, product};
            axis_in = 2'd1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in = acc_ff + {2'b00, product};
            axis_in = 2'd2;
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            acc_in = acc_ff + {2'b00, product};
            axis_in = 2'd0;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            sat_in = 1'b0;
            rrem_in = '0;
            root_in = '0;
            cnt_in = CntW'(RootSteps);
            if (covered && r1_ge_r2) begin
               grew_in = 1'b0;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (covered) begin
               cx_in = ix_ff; cy_in = iy_ff; cz_in = iz_ff; rad_in = ir_ff;
               grew_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            acc_in = {acc_ff[SumW-3:0], 2'b00};
            if (root_try >= root_trial) begin
               rrem_in = RootRemW'(root_try - root_trial);
               root_in = {root_ff[RootW-2:0], 1'b1};
            end else begin
               rrem_in = RootRemW'(root_try);
               root_in = {root_ff[RootW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) state_in = ST_SETK;
         end
         ST_SETK: begin
            nr_in = rsum[RootW:1];
            k_in = rsum[RootW:1] - {2'b00, rad_ff};
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Quotient stays below 2^33, so the upper half starts as remainder.
            drem_in = product[2*MagW-1:MagW];
            dlo_in = product[MagW-1:0];
            cnt_in = CntW'(DivSteps);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_try >= {1'b0, root_ff}) begin
               drem_in = MagW'(div_try - {1'b0, root_ff});
               dlo_in = {dlo_ff[MagW-2:0], 1'b1};
            end else begin
               drem_in = div_try[MagW-1:0];
               dlo_in = {dlo_ff[MagW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) state_in = ST_MOVE;
         end
         ST_MOVE: begin
            case (axis_ff)
               2'd0:    cx_in = moved[CoordW-1:0];
               2'd1:    cy_in = moved[CoordW-1:0];
               default: cz_in = moved[CoordW-1:0];
            endcase
            if (axis_ff == 2'd2) begin
               if (nr_ff[RootW-1:RadiusW] != 2'b00) begin
                  rad_in = '1;
                  sat_in = 1'b1;
               end else begin
                  rad_in = nr_ff[RadiusW-1:0];
               end
               grew_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               axis_in = axis_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0; rad_ff <= '0;
         cnt_ff <= '0;
         axis_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; rad_ff <= rad_in;
         cnt_ff <= cnt_in;
         axis_ff <= axis_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ix_ff <= ix_in; iy_ff <= iy_in; iz_ff <= iz_in; ir_ff <= ir_in;
      acc_ff <= acc_in; rrem_ff <= rrem_in; root_ff <= root_in;
      k_ff <= k_in; nr_ff <= nr_in; drem_ff <= drem_in; dlo_ff <= dlo_in;
      grew_ff <= grew_in; sat_ff <= sat_in;
   end

   `BSG_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE, "busy result")
   `BSG_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready, "ready after transfer")
   `BSG_ASSERT_NOW(a_div_rem, clock, reset, state_ff == ST_DIV, drem_ff < root_ff, "remainder")
   `BSG_ASSERT_NOW(a_sat_grew, clock, reset, rsp_valid_ff && sat_ff, grew_ff, "saturated unchanged")
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the bounding sphere grow block: directed and random streams.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bsg_pkg::*;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [30:0] r;
      logic        grew;
      logic        sat;
   } sphere_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   // Predicted sphere held by the testbench.
   logic signed [31:0] pred_x, pred_y, pred_z;
   logic [30:0]        pred_r;

   sphere_result_type  expected_spheres[$];
   int                 error_count = 0;
   int                 results_seen = 0;

   bounding_sphere_grow_top uut (.*);

   always #5 clock = ~clock;

   // Exact floor square root of a value below 2^68.
   function automatic logic [33:0] floor_sqrt(input logic [67:0] v);
      logic [69:0] rem;
      logic [35:0] root, trial;
      rem = '0;
      root = '0;
      for (int i = 33; i >= 0; i--) begin
         rem = (rem << 2) | ((v >> (2 * i)) & 68'd3);
         trial = (root << 2) | 36'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 36'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[33:0];
   endfunction

   // Moves one centre axis toward the incoming centre by delta*k/d, truncated.
   function automatic logic signed [31:0] shift_axis(input logic signed [31:0] c,
         input logic signed [33:0] delta, input logic [33:0] k, input logic [33:0] d);
      logic [33:0]  m;
      logic [67:0]  q;
      logic signed [35:0] res;
      m = delta < 0 ? -delta : delta;
      q = ({34'd0, m} * {34'd0, k}) / {34'd0, d};
      res = delta < 0 ? 36'(c) - 36'(q[33:0]) : 36'(c) + 36'(q[33:0]);
      return res[31:0];
   endfunction

   // Applies one item to the predicted sphere and returns the expected result.
   function automatic sphere_result_type grow_sphere(input logic kind,
         input logic signed [31:0] ix, input logic signed [31:0] iy,
         input logic signed [31:0] iz, input logic [30:0] ir);
      sphere_result_type res;
      logic signed [33:0] dx, dy, dz;
      logic [67:0] sumsq, t1, t2;
      logic [33:0] d, nr, k, r1;
      res.grew = 1'b1;
      res.sat = 1'b0;
      if (kind == KIND_LOAD) begin
         pred_x = ix; pred_y = iy; pred_z = iz; pred_r = ir;
      end else begin
         dx = 34'(ix) - 34'(pred_x);
         dy = 34'(iy) - 34'(pred_y);
         dz = 34'(iz) - 34'(pred_z);
         sumsq = 68'($unsigned(68'(dx) * 68'(dx))) + 68'($unsigned(68'(dy) * 68'(dy)))
               + 68'($unsigned(68'(dz) * 68'(dz)));
         r1 = {3'd0, pred_r};
         t1 = {37'd0, pred_r - ir};
         t2 = {37'd0, ir - pred_r};
         if (pred_r >= ir && t1 * t1 >= sumsq) begin
            res.grew = 1'b0;
         end else if (ir > pred_r && t2 * t2 >= sumsq) begin
            pred_x = ix; pred_y = iy; pred_z = iz; pred_r = ir;
         end else begin
            d = floor_sqrt(sumsq);
            nr = (r1 + {3'd0, ir} + d) >> 1;
            k = nr - r1;
            pred_x = shift_axis(pred_x, dx, k, d);
            pred_y = shift_axis(pred_y, dy, k, d);
            pred_z = shift_axis(pred_z, dz, k, d);
            if (nr > 34'h7FFF_FFFF) begin
               nr = 34'h7FFF_FFFF;
               res.sat = 1'b1;
            end
            pred_r = nr[30:0];
         end
      end
      res.x = pred_x; res.y = pred_y; res.z = pred_z; res.r = pred_r;
      return res;
   endfunction

   // Random gap: mostly short, now and then long. The request is dropped only over a gap.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Sends one item and records its expected result.
   task automatic send_item(input logic kind, input logic [31:0] ix, input logic [31:0] iy,
         input logic [31:0] iz, input logic [30:0] ir);
      idle_gap();
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, ir, iz, iy, ix};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_spheres.push_back(grow_sphere(kind, ix, iy, iz, ir));
   endtask

   // Stops sending and waits until every expected result has come.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_spheres.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(input int span);
      case (span)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 16;
         default: return 32'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   // Field extremes, both kinds, every merge outcome and radius saturation.
   task automatic test_directed();
      send_item(KIND_MERGE, 0, 0, 0, 0);
      send_item(KIND_MERGE, 32'h0001_0000, 0, 0, 0);
      send_item(KIND_MERGE, 0, 32'h0003_0000, 0, 31'h0001_0000);
      send_item(KIND_MERGE, 0, 0, 0, 31'h0010_0000);
      send_item(KIND_MERGE, 0, 0, 0, 31'h0001_0000);
      send_item(KIND_MERGE, 0, 0, 0, 31'h0010_0000);
      send_item(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_item(KIND_MERGE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
      send_item(KIND_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_item(KIND_MERGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_item(KIND_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send_item(KIND_LOAD, 0, 0, 0, 31'h0000_0005);
      send_item(KIND_MERGE, 32'h0000_0001, 0, 0, 31'h0000_0006);
      send_item(KIND_MERGE, 32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FFF7, 31'h0000_0003);
      send_item(KIND_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 31'h2AAA_AAAA);
      drain();
   endtask

   // Mostly merges with an occasional load, with assorted spans.
   task automatic test_random();
      int span;
      for (int i = 0; i < 1750; i++) begin
         span = $urandom_range(0, 2);
         if ($urandom_range(0, 15) == 0)
            send_item(KIND_LOAD, rand_coord(span), rand_coord(span), rand_coord(span),
                      $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 20)));
         else
            send_item(KIND_MERGE, rand_coord(span), rand_coord(span), rand_coord(span),
                      $urandom_range(0, 2) == 0 ? 31'($urandom) :
                      31'($urandom_range(0, 1 << 18)));
         if (i == 900) drain();
      end
   endtask

   // Result stall pattern and checking on every accepted transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      sphere_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_spheres.size() == 0) begin
            $error("result transfer with no item pending");
            error_count++;
         end else begin
            exp_r = expected_spheres.pop_front();
            if (rsp_tdata[31:0] !== exp_r.x) begin
               $error("out_x expected %h got %h", exp_r.x, rsp_tdata[31:0]); error_count++;
            end
            if (rsp_tdata[63:32] !== exp_r.y) begin
               $error("out_y expected %h got %h", exp_r.y, rsp_tdata[63:32]); error_count++;
            end
            if (rsp_tdata[95:64] !== exp_r.z) begin
               $error("out_z expected %h got %h", exp_r.z, rsp_tdata[95:64]); error_count++;
            end
            if (rsp_tdata[126:96] !== exp_r.r) begin
               $error("out_radius expected %h got %h", exp_r.r, rsp_tdata[126:96]);
               error_count++;
            end
            if (rsp_tdata[127] !== exp_r.grew) begin
               $error("grew expected %b got %b", exp_r.grew, rsp_tdata[127]); error_count++;
            end
            if (rsp_tdata[128] !== exp_r.sat) begin
               $error("saturated expected %b got %b", exp_r.sat, rsp_tdata[128]);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      pred_x = 0; pred_y = 0; pred_z = 0; pred_r = 0;
      test_directed();
      test_random();
      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_spheres.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Run limit: far above the slowest run with all stalls.
   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule
